FILE: hdl/cau_pkg.sv
// Shared command codes, status codes and pipeline tag type of the complex arithmetic unit.
`default_nettype none

package cau_pkg;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_SUB  = 3'd1;
  localparam logic [2:0] CMD_MUL  = 3'd2;
  localparam logic [2:0] CMD_DIV  = 3'd3;
  localparam logic [2:0] CMD_DIST = 3'd4;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_DZ  = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  // Control flags that travel with each word down the pipeline.
  typedef struct packed {
    logic [2:0] cmd;
    logic       sat;
    logic       dz;
    logic       big;
    logic       neg_re;
    logic       neg_im;
    logic       ovf_re;
    logic       ovf_im;
  } cau_tag_t;

endpackage

`default_nettype wire

FILE: hdl/cau_if.sv
// Valid/ready channel interfaces for the operand and result words.
`default_nettype none

interface cau_in_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   cmd;
  logic signed [DATA_WIDTH-1:0] a_real;
  logic signed [DATA_WIDTH-1:0] a_imag;
  logic signed [DATA_WIDTH-1:0] b_real;
  logic signed [DATA_WIDTH-1:0] b_imag;

  modport source (output valid, cmd, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, cmd, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(parameter int DATA_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] res_real;
  logic signed [DATA_WIDTH-1:0] res_imag;
  logic [1:0]                   status;

  modport source (output valid, res_real, res_imag, status, input ready);
  modport sink (input valid, res_real, res_imag, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/cau_front.sv
// Front end: products, sums, saturation of the simple operations and divider set-up.
`default_nettype none

module cau_front import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  cau_in_if.sink                         in_s,
  input  wire logic                      dn_ready,
  output logic                           dn_valid,
  output cau_tag_t                       tag_o,
  output logic [DATA_WIDTH-1:0]          res_re_o,
  output logic [DATA_WIDTH-1:0]          res_im_o,
  output logic [2*DATA_WIDTH-1:0]        den_o,
  output logic [2*DATA_WIDTH-1:0]        rem_re_o,
  output logic [2*DATA_WIDTH-1:0]        rem_im_o,
  output logic [DATA_WIDTH-1:0]          x_re_o,
  output logic [DATA_WIDTH-1:0]          x_im_o,
  output logic [2*DATA_WIDTH-1:0]        sx_o
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam int HW = W + F;
  localparam int CW = (HW > PW) ? HW : PW;

  localparam logic [W-1:0] POS_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_W = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] POS_S = {{(PW-W+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] NEG_S = {{(PW-W+2){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [W:0] POS_D = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0] NEG_D = {2'b11, {(W-2){1'b0}}, 1'b1};

  // Returns the saturation flag above the clamped value.
  function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] x);
    logic [W:0] r;
    if (x > POS_S) begin
      r = {1'b1, POS_W};
    end else if (x < NEG_S) begin
      r = {1'b1, NEG_W};
    end else begin
      r = {1'b0, x[W-1:0]};
    end
    return r;
  endfunction

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign rdy4 = !v4_r || dn_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_s.ready = rdy1;

  // Stage 1: all multiplications, and the operand sums and differences.
  logic signed [W-1:0] ar, ai, br, bi;
  logic signed [W:0]   sr, si, dr, di;

  assign ar = in_s.a_real;
  assign ai = in_s.a_imag;
  assign br = in_s.b_real;
  assign bi = in_s.b_imag;
  assign sr = {ar[W-1], ar} + {br[W-1], br};
  assign si = {ai[W-1], ai} + {bi[W-1], bi};
  assign dr = {ar[W-1], ar} - {br[W-1], br};
  assign di = {ai[W-1], ai} - {bi[W-1], bi};

  logic [2:0]           cmd1_r;
  logic signed [PW-1:0] prr1_r, pii1_r, pri1_r, pir1_r;
  logic [PW-1:0]        qrr1_r, qii1_r;
  logic signed [W:0]    sr1_r, si1_r, dr1_r, di1_r;
  logic signed [PW+1:0] dsr1_r, dsi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_s.valid) begin
      cmd1_r <= in_s.cmd;
      prr1_r <= ar * br;
      pii1_r <= ai * bi;
      pri1_r <= ar * bi;
      pir1_r <= ai * br;
      qrr1_r <= br * br;
      qii1_r <= bi * bi;
      sr1_r  <= sr;
      si1_r  <= si;
      dr1_r  <= dr;
      di1_r  <= di;
      dsr1_r <= dr * dr;
      dsi1_r <= di * di;
    end
  end

  // Stage 2: sums of products, floor shift, saturation, divisor and squared-distance sums.
  logic signed [SW-1:0] pr, pi, nr, ni, pr_f, pi_f, sr_x, si_x, dr_x, di_x;
  logic [W:0]           er, ei;
  logic [PW-1:0]        den2, sq2;
  logic                 big2;
  cau_tag_t             tag2_n;

  assign pr   = {prr1_r[PW-1], prr1_r} - {pii1_r[PW-1], pii1_r};
  assign pi   = {pri1_r[PW-1], pri1_r} + {pir1_r[PW-1], pir1_r};
  assign nr   = {prr1_r[PW-1], prr1_r} + {pii1_r[PW-1], pii1_r};
  assign ni   = {pir1_r[PW-1], pir1_r} - {pri1_r[PW-1], pri1_r};
  assign pr_f = pr >>> F;
  assign pi_f = pi >>> F;
  assign sr_x = {{(SW-W-1){sr1_r[W]}}, sr1_r};
  assign si_x = {{(SW-W-1){si1_r[W]}}, si1_r};
  assign dr_x = {{(SW-W-1){dr1_r[W]}}, dr1_r};
  assign di_x = {{(SW-W-1){di1_r[W]}}, di1_r};
  assign den2 = qrr1_r + qii1_r;
  assign sq2  = dsr1_r[PW-1:0] + dsi1_r[PW-1:0];
  assign big2 = (dr1_r > POS_D) || (dr1_r < NEG_D) || (di1_r > POS_D) || (di1_r < NEG_D);

  always_comb begin
    er = '0;
    ei = '0;
    case (cmd1_r)
      CMD_ADD: begin
        er = sat_fn(sr_x);
        ei = sat_fn(si_x);
      end
      CMD_SUB: begin
        er = sat_fn(dr_x);
        ei = sat_fn(di_x);
      end
      CMD_MUL: begin
        er = sat_fn(pr_f);
        ei = sat_fn(pi_f);
      end
      default: begin
        er = '0;
        ei = '0;
      end
    endcase
    tag2_n     = '0;
    tag2_n.cmd = cmd1_r;
    tag2_n.sat = er[W] || ei[W];
    tag2_n.big = big2;
  end

  cau_tag_t             tag2_r;
  logic [W-1:0]         res_re2_r, res_im2_r;
  logic signed [SW-1:0] nr2_r, ni2_r;
  logic [PW-1:0]        den2_r, sq2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      tag2_r    <= tag2_n;
      res_re2_r <= er[W-1:0];
      res_im2_r <= ei[W-1:0];
      nr2_r     <= nr;
      ni2_r     <= ni;
      den2_r    <= den2;
      sq2_r     <= sq2;
    end
  end

  // Stage 3: numerator magnitudes and the zero divisor check.
  logic [SW-1:0] nabs_re, nabs_im;
  cau_tag_t      tag3_n;

  assign nabs_re = nr2_r[SW-1] ? (~nr2_r + 1'b1) : nr2_r;
  assign nabs_im = ni2_r[SW-1] ? (~ni2_r + 1'b1) : ni2_r;

  always_comb begin
    tag3_n        = tag2_r;
    tag3_n.neg_re = nr2_r[SW-1];
    tag3_n.neg_im = ni2_r[SW-1];
    tag3_n.dz     = (den2_r == '0);
  end

  cau_tag_t      tag3_r;
  logic [W-1:0]  res_re3_r, res_im3_r;
  logic [PW-1:0] nm_re3_r, nm_im3_r, den3_r, sq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      tag3_r    <= tag3_n;
      res_re3_r <= res_re2_r;
      res_im3_r <= res_im2_r;
      nm_re3_r  <= nabs_re[PW-1:0];
      nm_im3_r  <= nabs_im[PW-1:0];
      den3_r    <= den2_r;
      sq3_r     <= sq2_r;
    end
  end

  // Stage 4: the scaled numerator is split; its upper part seeds the remainder,
  // and a quotient that cannot fit is flagged here.
  logic [PW+F-1:0] num_re, num_im;
  logic [HW-1:0]   hi_re, hi_im;
  logic [CW-1:0]   hix_re, hix_im, denx;
  cau_tag_t        tag4_n;

  assign num_re = (PW+F)'(nm_re3_r) << F;
  assign num_im = (PW+F)'(nm_im3_r) << F;
  assign hi_re  = num_re[PW+F-1:W];
  assign hi_im  = num_im[PW+F-1:W];
  assign hix_re = CW'(hi_re);
  assign hix_im = CW'(hi_im);
  assign denx   = CW'(den3_r);

  always_comb begin
    tag4_n        = tag3_r;
    tag4_n.ovf_re = hix_re >= denx;
    tag4_n.ovf_im = hix_im >= denx;
  end

  cau_tag_t      tag4_r;
  logic [W-1:0]  res_re4_r, res_im4_r, x_re4_r, x_im4_r;
  logic [PW-1:0] den4_r, rem_re4_r, rem_im4_r, sx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      tag4_r    <= tag4_n;
      res_re4_r <= res_re3_r;
      res_im4_r <= res_im3_r;
      den4_r    <= den3_r;
      rem_re4_r <= hix_re[PW-1:0];
      rem_im4_r <= hix_im[PW-1:0];
      x_re4_r   <= num_re[W-1:0];
      x_im4_r   <= num_im[W-1:0];
      sx4_r     <= sq3_r;
    end
  end

  assign dn_valid = v4_r;
  assign tag_o    = tag4_r;
  assign res_re_o = res_re4_r;
  assign res_im_o = res_im4_r;
  assign den_o    = den4_r;
  assign rem_re_o = rem_re4_r;
  assign rem_im_o = rem_im4_r;
  assign x_re_o   = x_re4_r;
  assign x_im_o   = x_im4_r;
  assign sx_o     = sx4_r;

endmodule

`default_nettype wire

FILE: hdl/cau_iter.sv
// One pipeline stage of the long divisions and the square root: one result bit each.
`default_nettype none

module cau_iter import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire cau_tag_t                  tag_i,
  input  wire logic [DATA_WIDTH-1:0]     res_re_i,
  input  wire logic [DATA_WIDTH-1:0]     res_im_i,
  input  wire logic [2*DATA_WIDTH-1:0]   den_i,
  input  wire logic [2*DATA_WIDTH-1:0]   rem_re_i,
  input  wire logic [2*DATA_WIDTH-1:0]   rem_im_i,
  input  wire logic [DATA_WIDTH-1:0]     x_re_i,
  input  wire logic [DATA_WIDTH-1:0]     x_im_i,
  input  wire logic [2*DATA_WIDTH-1:0]   sx_i,
  input  wire logic [DATA_WIDTH+1:0]     srem_i,
  input  wire logic [DATA_WIDTH-1:0]     root_i,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output cau_tag_t                       tag_o,
  output logic [DATA_WIDTH-1:0]          res_re_o,
  output logic [DATA_WIDTH-1:0]          res_im_o,
  output logic [2*DATA_WIDTH-1:0]        den_o,
  output logic [2*DATA_WIDTH-1:0]        rem_re_o,
  output logic [2*DATA_WIDTH-1:0]        rem_im_o,
  output logic [DATA_WIDTH-1:0]          x_re_o,
  output logic [DATA_WIDTH-1:0]          x_im_o,
  output logic [2*DATA_WIDTH-1:0]        sx_o,
  output logic [DATA_WIDTH+1:0]          srem_o,
  output logic [DATA_WIDTH-1:0]          root_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;

  // Divisions: the next numerator bit leaves the top of x, the quotient bit
  // enters at the bottom, so after all stages x holds the quotient.
  logic [PW:0] t_re, t_im, d_re, d_im;
  logic        ge_re, ge_im;

  assign t_re  = {rem_re_i, x_re_i[W-1]};
  assign t_im  = {rem_im_i, x_im_i[W-1]};
  assign d_re  = t_re - {1'b0, den_i};
  assign d_im  = t_im - {1'b0, den_i};
  assign ge_re = t_re >= {1'b0, den_i};
  assign ge_im = t_im >= {1'b0, den_i};

  // Square root: two radicand bits per stage, one root bit out.
  logic [W+3:0] t_sq, trial, d_sq;
  logic         ge_sq;

  assign t_sq  = {srem_i, sx_i[PW-1:PW-2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign d_sq  = t_sq - trial;
  assign ge_sq = t_sq >= trial;

  logic v_r;

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  cau_tag_t      tag_r;
  logic [W-1:0]  res_re_r, res_im_r, x_re_r, x_im_r, root_r;
  logic [PW-1:0] den_r, rem_re_r, rem_im_r, sx_r;
  logic [W+1:0]  srem_r;

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      tag_r    <= tag_i;
      res_re_r <= res_re_i;
      res_im_r <= res_im_i;
      den_r    <= den_i;
      rem_re_r <= ge_re ? d_re[PW-1:0] : t_re[PW-1:0];
      rem_im_r <= ge_im ? d_im[PW-1:0] : t_im[PW-1:0];
      x_re_r   <= {x_re_i[W-2:0], ge_re};
      x_im_r   <= {x_im_i[W-2:0], ge_im};
      sx_r     <= {sx_i[PW-3:0], 2'b00};
      srem_r   <= ge_sq ? d_sq[W+1:0] : t_sq[W+1:0];
      root_r   <= {root_i[W-2:0], ge_sq};
    end
  end

  assign dn_valid = v_r;
  assign tag_o    = tag_r;
  assign res_re_o = res_re_r;
  assign res_im_o = res_im_r;
  assign den_o    = den_r;
  assign rem_re_o = rem_re_r;
  assign rem_im_o = rem_im_r;
  assign x_re_o   = x_re_r;
  assign x_im_o   = x_im_r;
  assign sx_o     = sx_r;
  assign srem_o   = srem_r;
  assign root_o   = root_r;

endmodule

`default_nettype wire

FILE: hdl/cau_back.sv
// Back end: signs and saturation of quotients and root, result selection, output register.
`default_nettype none

module cau_back import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  up_valid,
  output logic                       up_ready,
  input  wire cau_tag_t              tag_i,
  input  wire logic [DATA_WIDTH-1:0] res_re_i,
  input  wire logic [DATA_WIDTH-1:0] res_im_i,
  input  wire logic [DATA_WIDTH-1:0] q_re_i,
  input  wire logic [DATA_WIDTH-1:0] q_im_i,
  input  wire logic [DATA_WIDTH-1:0] root_i,
  cau_out_if.source                  out_m
);

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] POS_W = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_W = {1'b1, {(W-1){1'b0}}};

  // Applies the sign to a quotient magnitude; the flag sits above the value.
  function automatic logic [W:0] pack_fn(input logic neg, input logic ovf,
                                         input logic [W-1:0] q);
    logic [W:0] r;
    if (ovf) begin
      r = {1'b1, (neg ? NEG_W : POS_W)};
    end else if (neg) begin
      if (q > NEG_W) begin
        r = {1'b1, NEG_W};
      end else begin
        r = {1'b0, (~q + 1'b1)};
      end
    end else if (q[W-1]) begin
      r = {1'b1, POS_W};
    end else begin
      r = {1'b0, q};
    end
    return r;
  endfunction

  logic [W:0]   pk_re, pk_im;
  logic [W-1:0] rr_n, ri_n;
  logic [1:0]   st_n;
  logic         sat_n;

  assign pk_re = pack_fn(tag_i.neg_re, tag_i.ovf_re, q_re_i);
  assign pk_im = pack_fn(tag_i.neg_im, tag_i.ovf_im, q_im_i);

  always_comb begin
    rr_n  = '0;
    ri_n  = '0;
    sat_n = 1'b0;
    st_n  = STAT_OK;
    case (tag_i.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        rr_n  = res_re_i;
        ri_n  = res_im_i;
        sat_n = tag_i.sat;
      end
      CMD_DIV: begin
        if (tag_i.dz) begin
          st_n = STAT_DZ;
        end else begin
          rr_n  = pk_re[W-1:0];
          ri_n  = pk_im[W-1:0];
          sat_n = pk_re[W] || pk_im[W];
        end
      end
      CMD_DIST: begin
        if (tag_i.big || root_i[W-1]) begin
          rr_n  = POS_W;
          sat_n = 1'b1;
        end else begin
          rr_n = root_i;
        end
      end
      default: begin
        rr_n = '0;
      end
    endcase
    if (sat_n) begin
      st_n = STAT_SAT;
    end
  end

  logic         out_valid_r;
  logic [W-1:0] rr_r, ri_r;
  logic [1:0]   st_r;

  assign up_ready = !out_valid_r || out_m.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rr_r <= rr_n;
      ri_r <= ri_n;
      st_r <= st_n;
    end
  end

  assign out_m.valid    = out_valid_r;
  assign out_m.res_real = rr_r;
  assign out_m.res_imag = ri_r;
  assign out_m.status   = st_r;

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && st_r == STAT_DZ |-> rr_r == '0 && ri_r == '0)
    else $error("divide-by-zero word carries a nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> st_r == STAT_OK || st_r == STAT_DZ || st_r == STAT_SAT)
    else $error("undefined status code on the result word");

  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(up_valid))
    else $error("result word appeared without a word from the pipeline");

endmodule

`default_nettype wire

FILE: hdl/complex_arithmetic_unit.sv
// An accepted operand word passes four front stages, one divider/root stage per result bit
// and one output register on its way to its result word.
// Throughput: one word per cycle unless the output stalls; every stage holds its own valid
// bit, so bubbles close up and a word is taken while a result waits if a stage is empty.
// Reset (synchronous, active low) clears every valid bit; data registers keep their value.
`default_nettype none

module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cau_in_if.sink    in_s,
  cau_out_if.source out_m
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;

  logic          vld_a    [0:W];
  logic          rdy_a    [0:W];
  cau_tag_t      tag_a    [0:W];
  logic [W-1:0]  res_re_a [0:W];
  logic [W-1:0]  res_im_a [0:W];
  logic [PW-1:0] den_a    [0:W];
  logic [PW-1:0] rem_re_a [0:W];
  logic [PW-1:0] rem_im_a [0:W];
  logic [W-1:0]  x_re_a   [0:W];
  logic [W-1:0]  x_im_a   [0:W];
  logic [PW-1:0] sx_a     [0:W];
  logic [W+1:0]  srem_a   [0:W];
  logic [W-1:0]  root_a   [0:W];

  assign srem_a[0] = '0;
  assign root_a[0] = '0;

  cau_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_s),
    .dn_ready (rdy_a[0]),
    .dn_valid (vld_a[0]),
    .tag_o    (tag_a[0]),
    .res_re_o (res_re_a[0]),
    .res_im_o (res_im_a[0]),
    .den_o    (den_a[0]),
    .rem_re_o (rem_re_a[0]),
    .rem_im_o (rem_im_a[0]),
    .x_re_o   (x_re_a[0]),
    .x_im_o   (x_im_a[0]),
    .sx_o     (sx_a[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_iter
    cau_iter #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_iter (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_a[k]),
      .up_ready (rdy_a[k]),
      .tag_i    (tag_a[k]),
      .res_re_i (res_re_a[k]),
      .res_im_i (res_im_a[k]),
      .den_i    (den_a[k]),
      .rem_re_i (rem_re_a[k]),
      .rem_im_i (rem_im_a[k]),
      .x_re_i   (x_re_a[k]),
      .x_im_i   (x_im_a[k]),
      .sx_i     (sx_a[k]),
      .srem_i   (srem_a[k]),
      .root_i   (root_a[k]),
      .dn_valid (vld_a[k+1]),
      .dn_ready (rdy_a[k+1]),
      .tag_o    (tag_a[k+1]),
      .res_re_o (res_re_a[k+1]),
      .res_im_o (res_im_a[k+1]),
      .den_o    (den_a[k+1]),
      .rem_re_o (rem_re_a[k+1]),
      .rem_im_o (rem_im_a[k+1]),
      .x_re_o   (x_re_a[k+1]),
      .x_im_o   (x_im_a[k+1]),
      .sx_o     (sx_a[k+1]),
      .srem_o   (srem_a[k+1]),
      .root_o   (root_a[k+1])
    );
  end

  cau_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld_a[W]),
    .up_ready (rdy_a[W]),
    .tag_i    (tag_a[W]),
    .res_re_i (res_re_a[W]),
    .res_im_i (res_im_a[W]),
    .q_re_i   (x_re_a[W]),
    .q_im_i   (x_im_a[W]),
    .root_i   (root_a[W]),
    .out_m    (out_m)
  );

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the complex arithmetic unit with a random valid/ready load.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam longint POS_LIM = 32767;
  localparam longint NEG_LIM = -32768;
  localparam int LATENCY = DW + 5;
  localparam int WATCHDOG = 3000;
  localparam int HOLD_LEN = 400;
  localparam int BURST_FROM = 1300;
  localparam int BURST_TO = 1800;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [15:0] ar, ai, br, bi;
  } operands_t;

  typedef struct {
    logic signed [15:0] re, im;
    logic [1:0]         status;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cau_in_if #(.DATA_WIDTH(DW)) in_ch ();
  cau_out_if #(.DATA_WIDTH(DW)) out_ch ();

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(8)) dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_ch),
    .out_m(out_ch)
  );

  always #4 clk = ~clk;

  operands_t pending_ops[$];
  answer_t   awaited[$];
  logic      sending = 1'b1;
  logic      hold_req = 1'b0;
  int        cycle = 0;
  int        quiet = 0;
  int        accepted = 0;
  int        mismatches = 0;
  int        hold_left = 0;

  // Clamp to the signed word range, noting when it bites.
  function automatic logic [15:0] clamp(longint v, inout bit sat);
    if (v > POS_LIM) begin
      sat = 1'b1;
      return 16'h7fff;
    end
    if (v < NEG_LIM) begin
      sat = 1'b1;
      return 16'h8000;
    end
    return v[15:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic answer_t complex_result(operands_t op);
    answer_t a;
    bit sat = 1'b0;
    longint ar = op.ar, ai = op.ai, br = op.br, bi = op.bi;
    longint den, dr, di;
    a.re = '0;
    a.im = '0;
    a.status = STAT_OK;
    case (op.cmd)
      CMD_ADD: begin
        a.re = clamp(ar + br, sat);
        a.im = clamp(ai + bi, sat);
      end
      CMD_SUB: begin
        a.re = clamp(ar - br, sat);
        a.im = clamp(ai - bi, sat);
      end
      CMD_MUL: begin
        // Arithmetic shift floors towards minus infinity.
        a.re = clamp((ar * br - ai * bi) >>> 8, sat);
        a.im = clamp((ar * bi + ai * br) >>> 8, sat);
      end
      CMD_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          a.status = STAT_DZ;
        end else begin
          // Integer division truncates towards zero, as the block does.
          a.re = clamp(((ar * br + ai * bi) * 256) / den, sat);
          a.im = clamp(((ai * br - ar * bi) * 256) / den, sat);
        end
      end
      CMD_DIST: begin
        dr = ar - br;
        di = ai - bi;
        if (dr < 0) dr = -dr;
        if (di < 0) di = -di;
        if (dr > POS_LIM || di > POS_LIM) begin
          a.re = 16'h7fff;
          sat = 1'b1;
        end else begin
          a.re = clamp(longint'(root_floor(dr * dr + di * di)), sat);
        end
      end
      default: ;
    endcase
    if (sat) a.status = STAT_SAT;
    return a;
  endfunction

  function automatic logic [15:0] pick_value();
    int sel = $urandom_range(0, 9);
    if (sel < 4) return 16'($signed($urandom_range(0, 4095)) - 2048);
    if (sel == 4) return 16'($urandom_range(0, 1) ? 16'h7fff - $urandom_range(0, 3)
                                                  : 16'h8000 + $urandom_range(0, 3));
    if (sel == 5) return 16'($signed($urandom_range(0, 15)) - 8);
    return 16'($urandom);
  endfunction

  task automatic queue_op(logic [2:0] c, logic [15:0] ar, logic [15:0] ai,
                          logic [15:0] br, logic [15:0] bi);
    operands_t op;
    op.cmd = c;
    op.ar = ar;
    op.ai = ai;
    op.br = br;
    op.bi = bi;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random(int n);
    logic [2:0] c;
    logic [15:0] br, bi;
    repeat (n) begin
      c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      br = pick_value();
      bi = pick_value();
      if (c == CMD_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      queue_op(c, pick_value(), pick_value(), br, bi);
    end
  endtask

  // Driver: offers queued words, idling at random outside the burst window.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (in_ch.valid && in_ch.ready) begin
      awaited.push_back(complex_result('{in_ch.cmd, in_ch.a_real, in_ch.a_imag,
                                         in_ch.b_real, in_ch.b_imag}));
      accepted <= accepted + 1;
    end
    if (rst_n && (!in_ch.valid || in_ch.ready)) begin
      if (sending && pending_ops.size() > 0 &&
          ((cycle > BURST_FROM && cycle < BURST_TO) || $urandom_range(0, 99) >= 34)) begin
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= pending_ops[0].cmd;
        in_ch.a_real <= pending_ops[0].ar;
        in_ch.a_imag <= pending_ops[0].ai;
        in_ch.b_real <= pending_ops[0].br;
        in_ch.b_imag <= pending_ops[0].bi;
        void'(pending_ops.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, one long hold, and the comparison.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) begin
      if (awaited.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("Unexpected result word: re=%0d im=%0d status=%0d",
                   out_ch.res_real, out_ch.res_imag, out_ch.status);
      end else begin
        if (out_ch.res_real !== awaited[0].re || out_ch.res_imag !== awaited[0].im ||
            out_ch.status !== awaited[0].status) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("Mismatch: expected re=%0d im=%0d status=%0d, got re=%0d im=%0d status=%0d",
                     awaited[0].re, awaited[0].im, awaited[0].status,
                     out_ch.res_real, out_ch.res_imag, out_ch.status);
        end
        void'(awaited.pop_front());
      end
    end
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (cycle > BURST_FROM && cycle < BURST_TO) || $urandom_range(0, 99) >= 34;
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int drain;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ADD;
    in_ch.a_real = '0;
    in_ch.a_imag = '0;
    in_ch.b_real = '0;
    in_ch.b_imag = '0;
    out_ch.ready = 1'b0;

    // Directed words: range ends, every command, zero divisor and unused codes.
    queue_op(CMD_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_op(CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_op(CMD_ADD, 16'h0100, 16'hff00, 16'h0080, 16'h0000);
    queue_op(CMD_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    queue_op(CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h0001);
    queue_op(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_op(CMD_MUL, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    queue_op(CMD_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    queue_op(CMD_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    queue_op(CMD_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
    queue_op(CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    queue_op(CMD_DIV, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_op(CMD_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
    queue_op(CMD_DIV, 16'hff00, 16'h0080, 16'h0300, 16'hfd00);
    queue_op(CMD_DIST, 16'h7fff, 16'h0000, 16'h8000, 16'h0000);
    queue_op(CMD_DIST, 16'h0300, 16'h0400, 16'h0000, 16'h0000);
    queue_op(CMD_DIST, 16'h5000, 16'h5000, 16'h0000, 16'h0000);
    queue_op(CMD_DIST, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
    queue_op(3'd5, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_op(3'd6, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    queue_op(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    queue_random(400);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (accepted >= 150);
    @(posedge clk);
    hold_req <= 1'b1;

    wait (pending_ops.size() == 0);
    @(posedge clk);
    sending <= 1'b0;
    wait (awaited.size() == 0 && !in_ch.valid);
    @(posedge clk);
    queue_random(730);
    sending <= 1'b1;

    wait (pending_ops.size() == 0);
    wait (!in_ch.valid);
    drain = 0;
    while (awaited.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/cau_pkg.sv
hdl/cau_if.sv
hdl/cau_front.sv
hdl/cau_iter.sv
hdl/cau_back.sv
hdl/complex_arithmetic_unit.sv
sim/tb.sv
